### rtl/hic_pkg.sv
// Shared types and constants for the heartbeat interval classifier.
`timescale 1ns / 1ps

package hic_pkg;

   // Field widths
   localparam int SAMPLE_WIDTH = 12;
   localparam int RATE_WIDTH   = 14;
   localparam int STATUS_WIDTH = 3;
   localparam int IVAL_WIDTH   = 16;
   localparam int CFG_WIDTH    = 12;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Serial divider: the scale fits in 16 bits, one quotient bit per step
   localparam int SCALE_WIDTH = 16;
   localparam int QUO_STEPS   = 16;
   localparam int STEP_WIDTH  = 4;

   // Three-rate average: sum of three saturated rates, times ceil(2^17/3)
   localparam int SUM_WIDTH   = 16;
   localparam int PROD_WIDTH  = 32;
   localparam int RECIP_SHIFT = 17;
   localparam logic [SUM_WIDTH-1:0] RECIP_THIRD = 16'hAAAB;

   localparam logic [RATE_WIDTH-1:0] RATE_MAX = 14'h3FFF;

   // Band limits in beats per minute
   localparam logic [RATE_WIDTH-1:0] BAND_LOW_MIN  = 14'd30;
   localparam logic [RATE_WIDTH-1:0] BAND_OK_MIN   = 14'd45;
   localparam logic [RATE_WIDTH-1:0] BAND_HIGH_MIN = 14'd80;
   localparam logic [RATE_WIDTH-1:0] BAND_VHIGH_MIN = 14'd100;

   // Rate status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_VERY_LOW  = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_LOW       = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_HIGH      = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_VERY_HIGH = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SKIPPED   = 3'd5;

   // Request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   // Register indexes (word index taken from the address)
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_MARGIN    = 1'b1;

   localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 12'd2650;
   localparam logic [CFG_WIDTH-1:0] MARGIN_RESET    = 12'd100;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // take the request transaction
      logic div_step;   // advance the divider by one quotient bit
      logic sum_load;   // saturate the rate and form the three-rate sum
      logic prod_load;  // multiply the sum by the reciprocal of three
      logic finish;     // load the result register and shift rate history
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic beat;       // the offered sample fires the trigger
      logic div_last;   // divider is on its final step
   } dp_status_type;

endpackage

### rtl/hic_csr.sv
// Configuration register file: beat threshold and re-arm margin.
`timescale 1ns / 1ps

module hic_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hic_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [hic_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [hic_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output logic [hic_pkg::CFG_WIDTH-1:0]       threshold,
   output logic [hic_pkg::CFG_WIDTH-1:0]       margin
);

   logic [hic_pkg::CFG_WIDTH-1:0] threshold_ff, threshold_in;
   logic [hic_pkg::CFG_WIDTH-1:0] margin_ff, margin_in;
   logic                          wr_en;
   logic                          reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   // Decode the write
   always_comb begin
      threshold_in = threshold_ff;
      margin_in    = margin_ff;
      if (wr_en) begin
         case (reg_sel)
            hic_pkg::REG_THRESHOLD: threshold_in = csr_pwdata[hic_pkg::CFG_WIDTH-1:0];
            hic_pkg::REG_MARGIN:    margin_in    = csr_pwdata[hic_pkg::CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= hic_pkg::THRESHOLD_RESET;
         margin_ff    <= hic_pkg::MARGIN_RESET;
      end else begin
         threshold_ff <= threshold_in;
         margin_ff    <= margin_in;
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_sel)
         hic_pkg::REG_THRESHOLD:
            csr_prdata = hic_pkg::CSR_DATA_WIDTH'(threshold_ff);
         hic_pkg::REG_MARGIN:
            csr_prdata = hic_pkg::CSR_DATA_WIDTH'(margin_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign threshold = threshold_ff;
   assign margin    = margin_ff;

endmodule

### rtl/hic_ctrl.sv
// Controller state machine: sequences beat processing and owns the result valid.
`timescale 1ns / 1ps

module hic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_kind,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output hic_pkg::ctrl_cmd_type  cmd,
   input  hic_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == hic_pkg::REQ_SAMPLE) && status.beat) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.prod_load = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register can take the new transaction
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/hic_dp.sv
// Datapath: trigger, tick counter, histories, serial divider, average and result register.
`timescale 1ns / 1ps

module hic_dp #(
   parameter int TICK_WIDTH = 16,
   parameter int RATE_SCALE = 12000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hic_pkg::ctrl_cmd_type               cmd,
   output hic_pkg::dp_status_type              status,
   input  logic                                req_kind,
   input  logic [hic_pkg::SAMPLE_WIDTH-1:0]    sample,
   input  logic [hic_pkg::CFG_WIDTH-1:0]       threshold,
   input  logic [hic_pkg::CFG_WIDTH-1:0]       margin,
   output logic [hic_pkg::RATE_WIDTH-1:0]      instant_rate,
   output logic [hic_pkg::RATE_WIDTH-1:0]      average_rate,
   output logic [hic_pkg::STATUS_WIDTH-1:0]    rate_status,
   output logic [hic_pkg::IVAL_WIDTH-1:0]      interval_ticks
);

   localparam int TW = TICK_WIDTH;
   localparam int RW = hic_pkg::RATE_WIDTH;
   localparam int IW = hic_pkg::IVAL_WIDTH;
   localparam int QW = hic_pkg::SCALE_WIDTH;
   localparam int SW = hic_pkg::SUM_WIDTH;
   localparam int PW = hic_pkg::PROD_WIDTH;
   localparam int CW = hic_pkg::CFG_WIDTH;
   localparam logic [QW-1:0] SCALE_VEC = QW'(RATE_SCALE);
   localparam logic [hic_pkg::STEP_WIDTH-1:0] STEP_LAST =
      hic_pkg::STEP_WIDTH'(hic_pkg::QUO_STEPS - 1);

   // Control state
   logic                          fired_ff, fired_in;
   logic                          skip_ff, skip_in;
   logic [TW-1:0]                 tick_ff, tick_in;
   logic [hic_pkg::STEP_WIDTH-1:0] step_ff, step_in;

   // Payload state
   logic [TW-1:0] hist0_ff, hist0_in;
   logic [TW-1:0] hist1_ff, hist1_in;
   logic [RW-1:0] rhist0_ff, rhist0_in;
   logic [RW-1:0] rhist1_ff, rhist1_in;
   logic [TW-1:0] ticks_ff, ticks_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [QW-1:0] dvd_ff, dvd_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rate_ff, rate_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [RW-1:0] out_rate_ff, out_rate_in;
   logic [RW-1:0] out_avg_ff, out_avg_in;
   logic [hic_pkg::STATUS_WIDTH-1:0] out_status_ff, out_status_in;
   logic [IW-1:0] out_ival_ff, out_ival_in;

   // Combinational helpers
   logic          is_sample;
   logic          beat;
   logic          rearm;
   logic [TW-1:0] tick_inc;
   logic [TW+3:0] five_ticks;
   logic [TW+3:0] nine_hist0;
   logic [TW+3:0] nine_hist1;
   logic          skip_hit;
   logic [TW:0]   rem_shift;
   logic [TW:0]   rem_diff;
   logic          quo_bit;
   logic [RW-1:0] rate_sat;
   logic [hic_pkg::STATUS_WIDTH-1:0] band;
   logic [IW-1:0] ival_sat;
   logic [CW:0]   rearm_sum;

   assign is_sample = (req_kind == hic_pkg::REQ_SAMPLE);

   // Trigger with hysteresis
   assign beat      = ~fired_ff & (sample > threshold);
   assign rearm_sum = {1'b0, sample} + {1'b0, margin};
   assign rearm     = fired_ff & (rearm_sum < {1'b0, threshold});

   // Saturating tick count, this sample included
   assign tick_inc = (&tick_ff) ? tick_ff : tick_ff + TW'(1);

   // Skipped-beat test: 5 * interval >= 9 * each of the two earlier intervals
   assign five_ticks = ({4'b0, tick_inc} << 2) + {4'b0, tick_inc};
   assign nine_hist0 = ({4'b0, hist0_ff} << 3) + {4'b0, hist0_ff};
   assign nine_hist1 = ({4'b0, hist1_ff} << 3) + {4'b0, hist1_ff};
   assign skip_hit   = (five_ticks >= nine_hist0) & (five_ticks >= nine_hist1);

   // One restoring-division step
   assign rem_shift = {rem_ff, dvd_ff[QW-1]};
   assign rem_diff  = rem_shift - {1'b0, ticks_ff};
   assign quo_bit   = (rem_shift >= {1'b0, ticks_ff});

   // Saturate the quotient to the rate width
   assign rate_sat = (|quo_ff[QW-1:RW]) ? hic_pkg::RATE_MAX : quo_ff[RW-1:0];

   // Band of the registered rate
   always_comb begin
      if (rate_ff < hic_pkg::BAND_LOW_MIN) begin
         band = hic_pkg::STATUS_VERY_LOW;
      end else if (rate_ff < hic_pkg::BAND_OK_MIN) begin
         band = hic_pkg::STATUS_LOW;
      end else if (rate_ff < hic_pkg::BAND_HIGH_MIN) begin
         band = hic_pkg::STATUS_OK;
      end else if (rate_ff < hic_pkg::BAND_VHIGH_MIN) begin
         band = hic_pkg::STATUS_HIGH;
      end else begin
         band = hic_pkg::STATUS_VERY_HIGH;
      end
   end

   // Interval as reported, saturated to the field width
   if (TW > IW) begin : g_ival_sat
      assign ival_sat = (|ticks_ff[TW-1:IW]) ? {IW{1'b1}} : ticks_ff[IW-1:0];
   end else begin : g_ival_ext
      assign ival_sat = IW'(ticks_ff);
   end

   // Next-state logic
   always_comb begin
      fired_in      = fired_ff;
      skip_in       = skip_ff;
      tick_in       = tick_ff;
      step_in       = step_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      rhist0_in     = rhist0_ff;
      rhist1_in     = rhist1_ff;
      ticks_in      = ticks_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      rate_in       = rate_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      out_rate_in   = out_rate_ff;
      out_avg_in    = out_avg_ff;
      out_status_in = out_status_ff;
      out_ival_in   = out_ival_ff;

      // Take a request transaction
      if (cmd.accept) begin
         if (!is_sample) begin
            skip_in = 1'b0;
         end else if (beat) begin
            fired_in = 1'b1;
            tick_in  = '0;
            if (skip_hit) begin
               skip_in = 1'b1;
            end
            hist0_in = hist1_ff;
            hist1_in = tick_inc;
            ticks_in = tick_inc;
            rem_in   = '0;
            dvd_in   = SCALE_VEC;
            quo_in   = '0;
            step_in  = '0;
         end else begin
            tick_in = tick_inc;
            if (rearm) begin
               fired_in = 1'b0;
            end
         end
      end

      // Advance the divider
      if (cmd.div_step) begin
         rem_in  = quo_bit ? rem_diff[TW-1:0] : rem_shift[TW-1:0];
         quo_in  = {quo_ff[QW-2:0], quo_bit};
         dvd_in  = dvd_ff << 1;
         step_in = step_ff + hic_pkg::STEP_WIDTH'(1);
      end

      // Saturate the rate and sum the last three rates
      if (cmd.sum_load) begin
         rate_in = rate_sat;
         sum_in  = SW'(rhist0_ff) + SW'(rhist1_ff) + SW'(rate_sat);
      end

      // Divide by three through the reciprocal
      if (cmd.prod_load) begin
         prod_in = sum_ff * hic_pkg::RECIP_THIRD;
      end

      // Load the result and shift the rate history
      if (cmd.finish) begin
         out_rate_in   = rate_ff;
         out_avg_in    = prod_ff[hic_pkg::RECIP_SHIFT +: RW];
         out_status_in = skip_ff ? hic_pkg::STATUS_SKIPPED : band;
         out_ival_in   = ival_sat;
         rhist0_in     = rhist1_ff;
         rhist1_in     = rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fired_ff  <= 1'b0;
         skip_ff   <= 1'b0;
         tick_ff   <= '0;
         step_ff   <= '0;
         hist0_ff  <= '0;
         hist1_ff  <= '0;
         rhist0_ff <= '0;
         rhist1_ff <= '0;
      end else begin
         fired_ff  <= fired_in;
         skip_ff   <= skip_in;
         tick_ff   <= tick_in;
         step_ff   <= step_in;
         hist0_ff  <= hist0_in;
         hist1_ff  <= hist1_in;
         rhist0_ff <= rhist0_in;
         rhist1_ff <= rhist1_in;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff      <= ticks_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      quo_ff        <= quo_in;
      rate_ff       <= rate_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      out_rate_ff   <= out_rate_in;
      out_avg_ff    <= out_avg_in;
      out_status_ff <= out_status_in;
      out_ival_ff   <= out_ival_in;
   end

   assign status.beat     = beat;
   assign status.div_last = (step_ff == STEP_LAST);

   assign instant_rate   = out_rate_ff;
   assign average_rate   = out_avg_ff;
   assign rate_status    = out_status_ff;
   assign interval_ticks = out_ival_ff;

endmodule

### rtl/heartbeat_interval_classifier.sv
// Top level of the heartbeat interval classifier.
`timescale 1ns / 1ps

// Takes one pulse-sensor sample per request transaction (req_tuser = 0) or a
// clear of the sticky skipped-beat status (req_tuser = 1). A sample that is not
// a beat, and a clear, give no result. A beat holds off the next request until
// it is done: it is accepted, then the bit-serial divider forms RATE_SCALE /
// interval (one quotient bit per cycle), then comes the three-rate sum, then the
// reciprocal multiply that divides it by three, and last the load of the result
// register; that last step waits while an earlier result is still unread. The
// result register lets the block accept further samples while a result waits
// on rsp_tready.
// Registers: beat_threshold at byte address 0, rearm_margin at byte address 4.
module heartbeat_interval_classifier #(
   parameter int TICK_WIDTH = 16,
   parameter int RATE_SCALE = 12000
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [11:0] sample, [15:12] zero
   input  logic [0:0]                          req_tuser,   // [0] req_type
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [13:0] instant_rate, [27:14] average_rate, [30:28] rate_status,
   // [46:31] interval_ticks, [47] zero
   output logic [47:0]                         rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hic_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [hic_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [hic_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   hic_pkg::ctrl_cmd_type                cmd;
   hic_pkg::dp_status_type               status;
   logic [hic_pkg::CFG_WIDTH-1:0]        threshold;
   logic [hic_pkg::CFG_WIDTH-1:0]        margin;
   logic [hic_pkg::RATE_WIDTH-1:0]       instant_rate;
   logic [hic_pkg::RATE_WIDTH-1:0]       average_rate;
   logic [hic_pkg::STATUS_WIDTH-1:0]     rate_status;
   logic [hic_pkg::IVAL_WIDTH-1:0]       interval_ticks;

   hic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold),
      .margin      (margin)
   );

   hic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   hic_dp #(
      .TICK_WIDTH (TICK_WIDTH),
      .RATE_SCALE (RATE_SCALE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_tuser[0]),
      .sample         (req_tdata[hic_pkg::SAMPLE_WIDTH-1:0]),
      .threshold      (threshold),
      .margin         (margin),
      .instant_rate   (instant_rate),
      .average_rate   (average_rate),
      .rate_status    (rate_status),
      .interval_ticks (interval_ticks)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {1'b0, interval_ticks, rate_status, average_rate, instant_rate};

endmodule
